>>> hdl/tbnm_pkg.sv
// shared types and constants for the timestamp buffer with nearest-time lookup
package tbnm_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 40;
    localparam int HND_W  = 32;
    localparam int CFG_W  = 32;
    localparam int ENT_W  = 7;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_DROP  = 2'd2;

    localparam logic CFG_SPAN_LIMIT  = 1'b0;
    localparam logic CFG_KEEP_WINDOW = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] time_ms;
        logic [HND_W-1:0]  handle;
    } t_in_item;

    typedef struct packed {
        logic [HND_W-1:0] match_handle;
        logic [1:0]       status;
        logic [ENT_W-1:0] entries;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [HND_W-1:0]  handle;
    } t_entry;

    typedef struct packed {
        logic             shift;
        logic             rotate;
        logic             wr_en;
        logic [IDX_W-1:0] wr_pos;
        logic [IDX_W-1:0] last_pos;
        t_entry           wr_entry;
    } t_chain_ctl;

endpackage

>>> hdl/tbnm_cell.sv
// one storage cell of the entry chain, ordered oldest first
module tbnm_cell (
    input  logic                     i_clk,
    input  logic [tbnm_pkg::IDX_W-1:0] i_pos,
    input  tbnm_pkg::t_chain_ctl     i_ctl,
    input  tbnm_pkg::t_entry         i_next,
    input  tbnm_pkg::t_entry         i_head,
    output tbnm_pkg::t_entry         o_entry
);

    tbnm_pkg::t_entry r_entry;
    tbnm_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_en && (i_pos == i_ctl.wr_pos)) begin
            n_entry = i_ctl.wr_entry;
        end else if (i_ctl.rotate && (i_pos == i_ctl.last_pos)) begin
            n_entry = i_head;
        end else if (i_ctl.shift || i_ctl.rotate) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/timestamp_buffer_nearest_match.sv
// top level: timestamp fifo as a chain of cells with nearest-time lookup
// add: the new time is compared with the oldest entry, and if the gap exceeds the span
// limit, entries older than the keep window are pruned; query: the chain rotates once past
// the head comparator; delete: entries older than the given time are popped; unused mode:
// result only; one item at a time, the next taken in the cycle after the result loads
// synchronous active-low reset empties the buffer and restores the limits
module timestamp_buffer_nearest_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tbnm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tbnm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [tbnm_pkg::CFG_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GAP   = 5'b00010,
        S_PRUNE = 5'b00100,
        S_QUERY = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam int TW = tbnm_pkg::TIME_W;

    t_state r_state, n_state;
    logic [tbnm_pkg::CNT_W-1:0]  r_count, n_count;
    logic [TW-1:0]               r_time, n_time;
    logic [TW-1:0]               r_cutoff, n_cutoff;
    logic [tbnm_pkg::IDX_W-1:0]  r_scan, n_scan;
    logic [TW-1:0]               r_best_d, n_best_d;
    logic [tbnm_pkg::HND_W-1:0]  r_best_h, n_best_h;
    logic [1:0]                  r_res_status, n_res_status;
    logic                        r_out_valid, n_out_valid;
    tbnm_pkg::t_out_item         r_out_item, n_out_item;
    logic [tbnm_pkg::CFG_W-1:0]  r_span, r_keep;

    tbnm_pkg::t_chain_ctl        w_ctl;
    tbnm_pkg::t_entry            w_cells [tbnm_pkg::DEPTH];
    tbnm_pkg::t_entry            w_head;
    logic [tbnm_pkg::CNT_W-1:0]  w_cnt_m1;
    logic                        w_accept;
    logic                        w_full;
    logic [TW-1:0]               w_keep;
    logic [TW-1:0]               w_gap;
    logic [TW-1:0]               w_dist;
    logic                        w_pop;

    // chain of cells
    genvar k;
    generate
        for (k = 0; k < tbnm_pkg::DEPTH; k++) begin : g_cell
            tbnm_cell u_cell (
                .i_clk   (i_clk),
                .i_pos   (tbnm_pkg::IDX_W'(k)),
                .i_ctl   (w_ctl),
                .i_next  (w_cells[(k == tbnm_pkg::DEPTH - 1) ? k : k + 1]),
                .i_head  (w_cells[0]),
                .o_entry (w_cells[k])
            );
        end
    endgenerate

    assign w_head   = w_cells[0];
    assign w_cnt_m1 = r_count - 1'b1;
    assign w_full   = (r_count == tbnm_pkg::CNT_W'(tbnm_pkg::DEPTH));
    assign w_keep   = TW'(r_keep);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_gap    = (w_head.time_ms > r_time) ? (w_head.time_ms - r_time)
                                                : (r_time - w_head.time_ms);
    assign w_dist   = (w_head.time_ms > r_time) ? (w_head.time_ms - r_time)
                                                : (r_time - w_head.time_ms);
    assign w_pop    = (r_count != '0) && (w_head.time_ms < r_cutoff);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_time       = r_time;
        n_cutoff     = r_cutoff;
        n_scan       = r_scan;
        n_best_d     = r_best_d;
        n_best_h     = r_best_h;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;

        w_ctl.shift    = 1'b0;
        w_ctl.rotate   = 1'b0;
        w_ctl.wr_en    = 1'b0;
        w_ctl.wr_pos   = r_count[tbnm_pkg::IDX_W-1:0];
        w_ctl.last_pos = w_cnt_m1[tbnm_pkg::IDX_W-1:0];
        w_ctl.wr_entry.time_ms = i_in_item.time_ms;
        w_ctl.wr_entry.handle  = i_in_item.handle;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_time       = i_in_item.time_ms;
                    n_res_status = tbnm_pkg::STAT_OK;
                    n_best_h     = '0;
                    n_scan       = '0;
                    case (i_in_item.mode)
                        tbnm_pkg::MODE_ADD: begin
                            w_ctl.wr_en = 1'b1;
                            n_cutoff = (i_in_item.time_ms > w_keep) ?
                                       (i_in_item.time_ms - w_keep) : '0;
                            if (w_full) begin
                                w_ctl.shift  = 1'b1;
                                w_ctl.wr_pos = tbnm_pkg::IDX_W'(tbnm_pkg::DEPTH - 1);
                                n_res_status = tbnm_pkg::STAT_DROP;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            n_state = S_GAP;
                        end
                        tbnm_pkg::MODE_QUERY: begin
                            if (r_count == '0) begin
                                n_res_status = tbnm_pkg::STAT_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_QUERY;
                            end
                        end
                        tbnm_pkg::MODE_DELETE: begin
                            n_cutoff = i_in_item.time_ms;
                            n_state  = S_PRUNE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_GAP: begin
                n_state = (w_gap > TW'(r_span)) ? S_PRUNE : S_DONE;
            end
            S_PRUNE: begin
                if (w_pop) begin
                    w_ctl.shift = 1'b1;
                    n_count     = w_cnt_m1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QUERY: begin
                w_ctl.rotate = 1'b1;
                if ((r_scan == '0) || (w_dist < r_best_d)) begin
                    n_best_d = w_dist;
                    n_best_h = w_head.handle;
                end
                n_scan = r_scan + 1'b1;
                if (r_scan == w_cnt_m1[tbnm_pkg::IDX_W-1:0]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_item.match_handle = r_best_h;
                    n_out_item.status       = r_res_status;
                    n_out_item.entries      = tbnm_pkg::ENT_W'(r_count);
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_span      <= tbnm_pkg::CFG_W'(25000);
            r_keep      <= tbnm_pkg::CFG_W'(5000);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tbnm_pkg::CFG_SPAN_LIMIT:  r_span <= i_cfg_data;
                    tbnm_pkg::CFG_KEEP_WINDOW: r_keep <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time       <= n_time;
        r_cutoff     <= n_cutoff;
        r_scan       <= n_scan;
        r_best_d     <= n_best_d;
        r_best_h     <= n_best_h;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tbnm_pkg::CNT_W'(tbnm_pkg::DEPTH))
        else $error("entry count above depth");

    a_add_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_item.mode == tbnm_pkg::MODE_ADD)) |=> (r_count != '0))
        else $error("buffer empty right after add");

    a_prune_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRUNE && w_pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("prune pop did not drop one entry");

    a_query_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUERY) |=> $stable(r_count))
        else $error("entry count moved during query scan");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == tbnm_pkg::STAT_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries held");

endmodule
